// ----- rtl/wpm_pkg.sv -----
// Shared types, constants and character helpers for the word prefix matcher.
`default_nettype none

package wpm_pkg;

   localparam int MAX_PREFIX_LEN = 5;
   localparam int PREFIX_BYTES   = 5;
   localparam int PREFIX_W       = 8 * PREFIX_BYTES;
   localparam int PLEN_W         = 3;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = PREFIX_W;
   localparam int COUNT_W        = 32;
   localparam int LEN_W          = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_CHARS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_LENGTH = 1'd1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] word_number;
      logic [LEN_W-1:0]   word_length;
   } rsp_type;

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         to_lower = c + 8'h20;
      end else begin
         to_lower = c;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/word_prefix_matcher_core.sv -----
// Top level: splits a byte stream into words and reports words that start with the prefix.
`default_nettype none

// Takes one text byte per cycle and reports, at the end of each alphanumeric word,
// the word's number (from 1) and length (saturating at 255) when its first
// prefix_length characters (capped at 5) equal the prefix, ignoring case; a zero-length
// prefix matches every word, a word shorter than the prefix never does. One item per
// cycle sustained, with a registered result: the word state registers update at
// acceptance and the result register holds a finished result while the next item
// is taken; req_ready drops only while a held result is not being taken. end_of_text
// closes any open word and restarts word numbering at 1. The user must write
// configuration through csr_we/csr_index/csr_wdata while idle; it is not enforced.
module word_prefix_matcher_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire wpm_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output wpm_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_we,
   input  wire logic [wpm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [wpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [wpm_pkg::PREFIX_W-1:0] prefix_chars_ff;
   logic [wpm_pkg::PLEN_W-1:0]   prefix_length_ff;

   logic                         inside_word_ff, inside_word_in;
   logic [wpm_pkg::LEN_W-1:0]    chars_seen_ff, chars_seen_in;
   logic                         still_matching_ff, still_matching_in;
   logic [wpm_pkg::COUNT_W-1:0]  words_counted_ff, words_counted_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   wpm_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         accept;
   logic                         alnum;
   logic [wpm_pkg::PLEN_W-1:0]   active_len;
   logic [wpm_pkg::LEN_W-1:0]    cur_seen;
   logic                         cur_match;
   logic [wpm_pkg::COUNT_W-1:0]  cur_count;
   logic [7:0]                   pfx_byte;
   logic [wpm_pkg::LEN_W-1:0]    new_seen;
   logic                         new_match;
   logic                         emit;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_chars_ff  <= '0;
         prefix_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            wpm_pkg::CSR_PREFIX_CHARS:  prefix_chars_ff  <= csr_wdata;
            wpm_pkg::CSR_PREFIX_LENGTH: prefix_length_ff <= csr_wdata[wpm_pkg::PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (prefix_length_ff > wpm_pkg::PLEN_W'(wpm_pkg::MAX_PREFIX_LEN)) begin
         active_len = wpm_pkg::PLEN_W'(wpm_pkg::MAX_PREFIX_LEN);
      end else begin
         active_len = prefix_length_ff;
      end

      alnum = wpm_pkg::is_alnum(req_payload.text_byte);

      // An alphanumeric byte outside a word opens a fresh one.
      if (inside_word_ff) begin
         cur_seen  = chars_seen_ff;
         cur_match = still_matching_ff;
         cur_count = words_counted_ff;
      end else begin
         cur_seen  = '0;
         cur_match = 1'b1;
         cur_count = (words_counted_ff == '1) ? words_counted_ff : words_counted_ff + 1'b1;
      end

      if (cur_seen < wpm_pkg::LEN_W'(wpm_pkg::PREFIX_BYTES)) begin
         pfx_byte = prefix_chars_ff[8*cur_seen[2:0] +: 8];
      end else begin
         pfx_byte = 8'h00;
      end

      new_match = cur_match;
      if (cur_seen < wpm_pkg::LEN_W'(active_len) &&
          wpm_pkg::to_lower(req_payload.text_byte) != wpm_pkg::to_lower(pfx_byte)) begin
         new_match = 1'b0;
      end
      new_seen = (cur_seen == '1) ? cur_seen : cur_seen + 1'b1;

      inside_word_in    = inside_word_ff;
      chars_seen_in     = chars_seen_ff;
      still_matching_in = still_matching_ff;
      words_counted_in  = words_counted_ff;
      emit              = 1'b0;
      rsp_in            = rsp_ff;

      if (alnum) begin
         inside_word_in    = 1'b1;
         chars_seen_in     = new_seen;
         still_matching_in = new_match;
         words_counted_in  = cur_count;
         if (req_payload.end_of_text) begin
            emit = new_match && (new_seen >= wpm_pkg::LEN_W'(active_len));
            rsp_in.word_number = cur_count;
            rsp_in.word_length = new_seen;
         end
      end else if (inside_word_ff) begin
         inside_word_in = 1'b0;
         emit = still_matching_ff && (chars_seen_ff >= wpm_pkg::LEN_W'(active_len));
         rsp_in.word_number = words_counted_ff;
         rsp_in.word_length = chars_seen_ff;
      end

      if (req_payload.end_of_text) begin
         inside_word_in    = 1'b0;
         chars_seen_in     = '0;
         still_matching_in = 1'b1;
         words_counted_in  = '0;
      end

      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_word_ff    <= 1'b0;
         chars_seen_ff     <= '0;
         still_matching_ff <= 1'b1;
         words_counted_ff  <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            inside_word_ff    <= inside_word_in;
            chars_seen_ff     <= chars_seen_in;
            still_matching_ff <= still_matching_in;
            words_counted_ff  <= words_counted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.word_number != '0 && rsp_ff.word_length != '0))
      else $error("result with zero word number or length");

   a_open_word_counted: assert property (@(posedge clock) disable iff (reset)
      inside_word_ff |-> (words_counted_ff != '0 && chars_seen_ff != '0))
      else $error("open word without count or characters");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.end_of_text) |=>
         (!inside_word_ff && words_counted_ff == '0 && chars_seen_ff == '0))
      else $error("end of text did not clear word state");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> !req_ready || rsp_valid_ff)
      else $error("held result lost while stalled");
`endif

endmodule

`default_nettype wire
